// File: hdl/roal_pkg.sv
package roal_pkg;

  localparam int ADDR_W          = 64;
  localparam int CNT_W           = 32;
  localparam int DEF_MAX_REGIONS = 256;
  localparam int QUEUE_DEPTH     = 2;

  // partial overlaps only count below this ceiling
  localparam logic [CNT_W-1:0] MIN_CEILING = CNT_W'(999);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // one stored region
  typedef struct packed {
    logic [ADDR_W-1:0] rgn_lo;
    logic [ADDR_W-1:0] rgn_hi;
    logic [CNT_W-1:0]  count;
  } region_t;

  localparam int REGION_W = $bits(region_t);

  // classified item: for a query, lo/hi hold buffer start and wrapped end
  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [CNT_W-1:0]  count;
  } cmd_t;

endpackage

// File: hdl/roal_ram.sv
module roal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/roal_front.sv
module roal_front import roal_pkg::*; (
  input  logic [1:0]        op_i,
  input  logic [ADDR_W-1:0] region_start_i,
  input  logic [ADDR_W-1:0] region_end_i,
  input  logic [CNT_W-1:0]  region_accesses_i,
  input  logic [ADDR_W-1:0] buf_addr_i,
  input  logic [ADDR_W-1:0] buf_size_i,
  output cmd_t              cmd_o
);

  op_e op;
  logic [ADDR_W-1:0] buf_end;

  assign op = op_e'(op_i);

  // wrapped buffer end
  assign buf_end = buf_addr_i + buf_size_i;

  // pick the bounds that the back end compares against
  always_comb begin
    cmd_o.op    = op;
    cmd_o.count = region_accesses_i;
    if (op == OP_QUERY) begin
      cmd_o.lo = buf_addr_i;
      cmd_o.hi = buf_end;
    end else begin
      cmd_o.lo = region_start_i;
      cmd_o.hi = region_end_i;
    end
  end

endmodule

// File: hdl/roal_queue.sv
module roal_queue import roal_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t head_o,
  input  logic pop_i
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [LW-1:0] fill_q, fill_d;
  logic          do_push, do_pop;

  assign full_o  = (fill_q == LW'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + LW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - LW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // store the item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// File: hdl/roal_back.sv
module roal_back import roal_pkg::*; #(
  parameter int MAX_REGIONS = DEF_MAX_REGIONS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  cmd_t             q_cmd_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CNT_W-1:0] accesses_o,
  output logic             status_o
);

  localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic [CW-1:0]     rd_idx_q, rd_idx_d;
  logic              rd_valid_q, rd_valid_d;
  logic              rd_last_q, rd_last_d;
  logic [ADDR_W-1:0] lo_q, lo_d;
  logic [ADDR_W-1:0] hi_q, hi_d;
  logic [CNT_W-1:0]  best_q, best_d;
  logic [CNT_W-1:0]  res_acc_q, res_acc_d;
  logic              res_status_q, res_status_d;
  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  out_acc_q;
  logic              out_status_q;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  region_t           ram_wdata;
  logic [REGION_W-1:0] ram_rdata;
  region_t           entry;

  logic              out_free, out_load;
  logic              hit, partial, take;
  logic [CNT_W-1:0]  best_next;

  roal_ram #(
    .WIDTH (REGION_W),
    .DEPTH (MAX_REGIONS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign entry    = region_t'(ram_rdata);
  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;

  // classify the region just read against the buffer
  always_comb begin
    hit = ((lo_q <= entry.rgn_lo) && (entry.rgn_hi <= hi_q)) ||
          ((entry.rgn_lo <= lo_q) && (hi_q <= entry.rgn_hi));
    partial = !((entry.rgn_hi <= lo_q) || (entry.rgn_lo >= hi_q)) &&
              (((entry.rgn_lo >= lo_q) && (entry.rgn_lo < hi_q)) ||
               ((entry.rgn_hi > lo_q) && (entry.rgn_hi <= hi_q)));
    take      = partial && (entry.count != '0) && (entry.count < best_q);
    best_next = take ? entry.count : best_q;
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    rd_idx_d     = rd_idx_q;
    rd_valid_d   = 1'b0;
    rd_last_d    = rd_last_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    best_d       = best_q;
    res_acc_d    = res_acc_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_waddr    = fill_q[AW-1:0];
    ram_wdata    = '{rgn_lo: q_cmd_i.lo, rgn_hi: q_cmd_i.hi, count: q_cmd_i.count};
    ram_re       = 1'b0;
    ram_raddr    = rd_idx_q[AW-1:0];
    out_load     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          res_acc_d    = '0;
          res_status_d = STATUS_OK;
          state_d      = ST_FIN;
          case (q_cmd_i.op)
            OP_CLEAR: begin
              fill_d = '0;
            end
            OP_APPEND: begin
              if (fill_q < CW'(MAX_REGIONS)) begin
                ram_we = 1'b1;
                fill_d = fill_q + CW'(1);
              end else begin
                res_status_d = STATUS_FULL;
              end
            end
            OP_QUERY: begin
              lo_d = q_cmd_i.lo;
              hi_d = q_cmd_i.hi;
              if (fill_q != '0) begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                rd_idx_d   = CW'(1);
                rd_valid_d = 1'b1;
                rd_last_d  = (fill_q == CW'(1));
                best_d     = MIN_CEILING;
                state_d    = ST_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        // issue the next read while the current entry is checked
        if (rd_idx_q < fill_q) begin
          ram_re     = 1'b1;
          rd_idx_d   = rd_idx_q + CW'(1);
          rd_valid_d = 1'b1;
          rd_last_d  = ((rd_idx_q + CW'(1)) == fill_q);
        end
        if (rd_valid_q) begin
          best_d = best_next;
          if (hit) begin
            res_acc_d  = entry.count;
            rd_valid_d = 1'b0;
            state_d    = ST_FIN;
          end else if (rd_last_q) begin
            res_acc_d  = (best_next == MIN_CEILING) ? '0 : best_next;
            rd_valid_d = 1'b0;
            state_d    = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // hold a stalled result, load a finished one
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= rd_idx_d;
    rd_last_q    <= rd_last_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    best_q       <= best_d;
    res_acc_q    <= res_acc_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_acc_q    <= res_acc_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign accesses_o  = out_acc_q;
  assign status_o    = out_status_q;

endmodule

// File: hdl/region_overlap_access_lookup.sv
// Region table with overlap lookup. Items enter through a two-entry queue, so
// the input keeps taking items while the executing side is busy or its result
// is stalled. With the executing side idle and the output free, an accepted
// item is popped from the queue into the executing side, and its result is
// then loaded into the output register. A clear, append or unused op goes
// straight to the final state; a query walks the loaded regions through the
// single read port of the region memory, which delivers one region per cycle,
// and the walk stops early at the first containing or contained region. A
// stalled result holds the executing side in its final state. The region
// memory needs no clearing pass after reset: only entries below the fill
// count are ever read.
module region_overlap_access_lookup import roal_pkg::*; #(
  parameter int MAX_REGIONS = DEF_MAX_REGIONS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        op_i,
  input  logic [ADDR_W-1:0] region_start_i,
  input  logic [ADDR_W-1:0] region_end_i,
  input  logic [CNT_W-1:0]  region_accesses_i,
  input  logic [ADDR_W-1:0] buf_addr_i,
  input  logic [ADDR_W-1:0] buf_size_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CNT_W-1:0]  accesses_o,
  output logic              status_o
);

  cmd_t in_cmd;
  cmd_t head_cmd;
  logic q_full, q_valid, q_pop;

  roal_front u_front (
    .op_i              (op_i),
    .region_start_i    (region_start_i),
    .region_end_i      (region_end_i),
    .region_accesses_i (region_accesses_i),
    .buf_addr_i        (buf_addr_i),
    .buf_size_i        (buf_size_i),
    .cmd_o             (in_cmd)
  );

  roal_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .push_cmd_i (in_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (head_cmd),
    .pop_i      (q_pop)
  );

  roal_back #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .accesses_o  (accesses_o),
    .status_o    (status_o)
  );

  assign in_stall_o = q_full;

endmodule

// File: hdl/roal_checker.sv
module roal_checker import roal_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [CNT_W-1:0]  accesses_o,
  input logic              status_o
);

  // no result right after a reset cycle
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

  // a dropped append carries no count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_FULL) |-> (accesses_o == '0))
    else $error("full status with nonzero count");

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result holds its fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(accesses_o) && $stable(status_o))
    else $error("result changed while stalled");

endmodule

bind region_overlap_access_lookup roal_checker u_checker (.*);
